### hw/rtl/olte_pkg.sv
// Package for the ordered list table engine: field widths, opcodes, status codes
// and the command and status structs between the controller and the datapath.
// Depends on nothing.
package olte_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned ST_W   = 2;

  // opcodes
  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_EDIT   = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_GET    = 3'd4;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd5;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // start point of the walk pointer
  typedef enum logic [1:0] {
    PTR_ZERO     = 2'd0,
    PTR_COUNT    = 2'd1,
    PTR_POS_NEXT = 2'd2
  } ptr_sel_e;

  // controller to datapath
  typedef struct packed {
    logic             capture;     // load a new item
    logic             ptr_load;    // start a walk
    ptr_sel_e         ptr_sel;
    logic             walk;        // one walk step
    logic             walk_up;     // walk toward lower addresses, moving entries up
    logic             walk_wr;     // write back the entry read in the last step
    logic             rd_pos;      // read the entry at the item's position
    logic             wr_item;     // write the item's value
    logic             wr_at_count; // at the end of the list instead of the position
    logic             cnt_inc;
    logic             cnt_dec;
    logic             take_read;
    logic             set_found;
    logic             set_status;
    logic [ST_W-1:0]  status;
    logic             emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pos_gt_cnt;
    logic            pos_ge_cnt;
    logic            full;
    logic            more_up;
    logic            more_dn;
    logic            pend;
    logic            match;
  } sts_t;

endpackage

### hw/rtl/olte_ctrl.sv
// Controller for the ordered list table engine: one-hot state machine that
// sequences checks, entry walks and the result strobe. Depends on olte_pkg.
module olte_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  olte_pkg::sts_t sts_i,
  output olte_pkg::cmd_t cmd_o,
  output logic           busy_o,
  output logic           cfg_ready_o
);
  import olte_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_GET    = 7'b0000100,
    S_SHIFT  = 7'b0001000,
    S_SEARCH = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   is_insert;

  assign is_insert   = (sts_i.op == OP_INSERT);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_DONE;
        case (sts_i.op)
          OP_APPEND: begin
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              cmd_o.wr_item     = 1'b1;
              cmd_o.wr_at_count = 1'b1;
              cmd_o.cnt_inc     = 1'b1;
            end
          end
          OP_INSERT: begin
            if (sts_i.pos_gt_cnt) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_RANGE;
            end else if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              cmd_o.ptr_load = 1'b1;
              cmd_o.ptr_sel  = PTR_COUNT;
              state_d        = S_SHIFT;
            end
          end
          OP_EDIT: begin
            if (sts_i.pos_ge_cnt) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_RANGE;
            end else begin
              cmd_o.wr_item = 1'b1;
            end
          end
          OP_DELETE: begin
            if (sts_i.pos_ge_cnt) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_RANGE;
            end else begin
              cmd_o.ptr_load = 1'b1;
              cmd_o.ptr_sel  = PTR_POS_NEXT;
              state_d        = S_SHIFT;
            end
          end
          OP_GET: begin
            if (sts_i.pos_ge_cnt) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_RANGE;
            end else begin
              cmd_o.rd_pos = 1'b1;
              state_d      = S_GET;
            end
          end
          OP_SEARCH: begin
            cmd_o.ptr_load = 1'b1;
            cmd_o.ptr_sel  = PTR_ZERO;
            state_d        = S_SEARCH;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_GET: begin
        cmd_o.take_read = 1'b1;
        state_d         = S_DONE;
      end
      // move entries one place, read and write overlapped
      S_SHIFT: begin
        cmd_o.walk    = 1'b1;
        cmd_o.walk_wr = 1'b1;
        cmd_o.walk_up = is_insert;
        if (!(is_insert ? sts_i.more_up : sts_i.more_dn) && !sts_i.pend) begin
          state_d = S_FINISH;
        end
      end
      // compare each entry read in the previous step
      S_SEARCH: begin
        cmd_o.walk = 1'b1;
        if (sts_i.match) begin
          cmd_o.set_found = 1'b1;
          state_d         = S_DONE;
        end else if (!sts_i.more_dn && !sts_i.pend) begin
          state_d = S_DONE;
        end
      end
      S_FINISH: begin
        if (is_insert) begin
          cmd_o.wr_item = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end else begin
          cmd_o.cnt_dec = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/olte_datapath.sv
// Datapath for the ordered list table engine: entry memory, count and capacity
// registers, walk pointer and result registers. Depends on olte_pkg.
module olte_datapath #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  olte_pkg::cmd_t                      cmd_i,
  output olte_pkg::sts_t                      sts_o,
  input  logic                                cfg_we_i,
  input  logic [olte_pkg::CNT_W-1:0]          cfg_data_i,
  input  logic [olte_pkg::OP_W-1:0]           opcode_i,
  input  logic [olte_pkg::POS_W-1:0]          position_i,
  input  logic signed [olte_pkg::DATA_W-1:0]  item_value_i,
  output logic                                result_valid_o,
  output logic [olte_pkg::ST_W-1:0]           status_o,
  output logic signed [olte_pkg::DATA_W-1:0]  read_value_o,
  output logic                                found_o,
  output logic [olte_pkg::POS_W-1:0]          found_position_o,
  output logic [olte_pkg::CNT_W-1:0]          entry_count_o,
  output logic                                is_empty_o,
  output logic                                is_full_o
);
  import olte_pkg::*;

  localparam int unsigned AW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
  localparam int unsigned CAP_MAX = (MAX_ENTRIES > CNT_MAX) ? CNT_MAX : MAX_ENTRIES;
  localparam logic [CNT_W-1:0] CAP_TOP = CNT_W'(CAP_MAX);
  localparam logic [CNT_W-1:0] CAP_MIN = CNT_W'(1);

  logic [DATA_W-1:0] entry_mem [MAX_ENTRIES];

  logic [OP_W-1:0]   op_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [CNT_W-1:0]  ptr_q, ra_q, count_q, cap_q;
  logic              pend_q;
  logic [DATA_W-1:0] rdata_q, rdv_q;
  logic [ST_W-1:0]   status_q;
  logic              found_q;
  logic [POS_W-1:0]  fpos_q;
  logic              valid_q;

  logic [CNT_W-1:0]  pos_ext, rd_addr, wr_addr, cap_d;
  logic [DATA_W-1:0] wr_data;
  logic              walk_more, rd_en, wr_en;

  assign pos_ext = {1'b0, pos_q};

  // status toward the controller
  assign sts_o.op         = op_q;
  assign sts_o.pos_gt_cnt = (pos_ext > count_q);
  assign sts_o.pos_ge_cnt = (pos_ext >= count_q);
  assign sts_o.full       = (count_q >= cap_q);
  assign sts_o.more_up    = (ptr_q > pos_ext);
  assign sts_o.more_dn    = (ptr_q < count_q);
  assign sts_o.pend       = pend_q;
  assign sts_o.match      = pend_q && (rdata_q == val_q);

  assign walk_more = cmd_i.walk_up ? sts_o.more_up : sts_o.more_dn;

  // memory port selection
  always_comb begin
    rd_en   = cmd_i.rd_pos | (cmd_i.walk & walk_more);
    rd_addr = cmd_i.rd_pos ? pos_ext : (cmd_i.walk_up ? ptr_q - 1'b1 : ptr_q);
    wr_en   = cmd_i.wr_item | (cmd_i.walk & cmd_i.walk_wr & pend_q);
    if (cmd_i.wr_item) begin
      wr_addr = cmd_i.wr_at_count ? count_q : pos_ext;
      wr_data = val_q;
    end else begin
      wr_addr = cmd_i.walk_up ? ra_q + 1'b1 : ra_q - 1'b1;
      wr_data = rdata_q;
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[AW'(wr_addr)] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= entry_mem[AW'(rd_addr)];
    end
  end

  // capacity clamp
  always_comb begin
    cap_d = cfg_data_i;
    if (cfg_data_i < CAP_MIN) begin
      cap_d = CAP_MIN;
    end else if (cfg_data_i > CAP_TOP) begin
      cap_d = CAP_TOP;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CAP_TOP;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cfg_we_i) begin
        cap_q   <= cap_d;
        count_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.ptr_load) begin
        pend_q <= 1'b0;
      end else if (cmd_i.walk) begin
        pend_q <= walk_more;
      end
    end
  end

  // item and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= opcode_i;
      pos_q    <= position_i;
      val_q    <= item_value_i;
      status_q <= ST_OK;
      rdv_q    <= '0;
      found_q  <= 1'b0;
      fpos_q   <= '0;
    end
    if (cmd_i.ptr_load) begin
      case (cmd_i.ptr_sel)
        PTR_COUNT:    ptr_q <= count_q;
        PTR_POS_NEXT: ptr_q <= pos_ext + 1'b1;
        default:      ptr_q <= '0;
      endcase
    end else if (cmd_i.walk && walk_more) begin
      ptr_q <= cmd_i.walk_up ? ptr_q - 1'b1 : ptr_q + 1'b1;
      ra_q  <= rd_addr;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.take_read) begin
      rdv_q <= rdata_q;
    end
    if (cmd_i.set_found) begin
      found_q <= 1'b1;
      fpos_q  <= ra_q[POS_W-1:0];
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_o         <= status_q;
      read_value_o     <= rdv_q;
      found_o          <= found_q;
      found_position_o <= fpos_q;
      entry_count_o    <= count_q;
      is_empty_o       <= (count_q == '0);
      is_full_o        <= (count_q >= cap_q);
    end
  end

  assign result_valid_o = valid_q;

endmodule

### hw/rtl/ordered_list_table_engine_unit.sv
// Top level of the ordered list table engine: controller plus datapath.
// Depends on olte_pkg, olte_ctrl and olte_datapath.
//
//  channel   direction  handshake                 payload
//  command   in         start, busy               opcode_i, position_i, item_value_i
//  result    out        result_valid_o (strobe)   status_o .. is_full_o
//  config    in         cfg_valid_i, cfg_ready_o  cfg_data_i (capacity in use)
//
// Append, edit and error results pass through the check and done states; get
// adds a read state between them. Insert and delete walk the entries to be moved
// and then pass a finish state; search compares entries up to the match or the
// count. The entry walk moves or compares one entry per cycle, and a new item is
// taken only once the state machine is back in idle.
// Reset empties the list and sets the capacity to the table size.
// The result strobe lasts one cycle and cannot be stalled; busy stays high
// until the cycle of the strobe, and configuration is taken only while idle.
module ordered_list_table_engine_unit #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [olte_pkg::OP_W-1:0]           opcode_i,
  input  logic [olte_pkg::POS_W-1:0]          position_i,
  input  logic signed [olte_pkg::DATA_W-1:0]  item_value_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [olte_pkg::CNT_W-1:0]          cfg_data_i,
  output logic                                result_valid_o,
  output logic [olte_pkg::ST_W-1:0]           status_o,
  output logic signed [olte_pkg::DATA_W-1:0]  read_value_o,
  output logic                                found_o,
  output logic [olte_pkg::POS_W-1:0]          found_position_o,
  output logic [olte_pkg::CNT_W-1:0]          entry_count_o,
  output logic                                is_empty_o,
  output logic                                is_full_o
);
  import olte_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign cfg_we = cfg_valid_i & cfg_ready_o;

  // sequencing
  olte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .cfg_ready_o (cfg_ready_o)
  );

  // storage and results
  olte_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (opcode_i),
    .position_i       (position_i),
    .item_value_i     (item_value_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .read_value_o     (read_value_o),
    .found_o          (found_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o),
    .is_empty_o       (is_empty_o),
    .is_full_o        (is_full_o)
  );

endmodule

### hw/rtl/olte_checker.sv
// Port-level checks for the ordered list table engine, bound to the top level.
// Depends on olte_pkg and ordered_list_table_engine_unit.
module olte_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                cfg_ready_o,
  input logic                                result_valid_o,
  input logic [olte_pkg::ST_W-1:0]           status_o,
  input logic                                found_o,
  input logic [olte_pkg::CNT_W-1:0]          entry_count_o,
  input logic                                is_empty_o
);
  import olte_pkg::*;

  // an accepted item keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a strobe comes only at the end of a busy stretch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy) && !busy))
    else $error("result strobe without a finished item");

  // config is never open while an item is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_ready_o && busy))
    else $error("config ready while busy");

  // empty flag follows the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with count");

  // a found match comes only from a clean search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && found_o) |-> (status_o == ST_OK))
    else $error("found flag with error status");

endmodule

bind ordered_list_table_engine_unit olte_checker u_olte_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .cfg_ready_o      (cfg_ready_o),
  .result_valid_o   (result_valid_o),
  .status_o         (status_o),
  .found_o          (found_o),
  .entry_count_o    (entry_count_o),
  .is_empty_o       (is_empty_o)
);
